// ===== hw/rtl/dcd_pkg.sv =====
// Shared types and constants for the cycle detector.
`default_nettype none
package dcd_pkg;
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROOT,
        ST_STEP,
        ST_ANSWER,
        ST_CLEAR
    } dcd_state_t;

    localparam logic [1:0] MARK_FREE = 2'd0;
    localparam logic [1:0] MARK_PATH = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    // Search sub-steps: issue the row and mark reads, use them, reload the parent.
    localparam logic [1:0] PH_ISSUE  = 2'd0;
    localparam logic [1:0] PH_USE    = 2'd1;
    localparam logic [1:0] PH_RELOAD = 2'd2;
endpackage
`default_nettype wire

// ===== hw/rtl/dcd_adj_mem.sv =====
// Adjacency matrix: one row per node, one bit per target, row read registered.
`default_nettype none
module dcd_adj_mem #(
    parameter int NODES = 64,
    parameter int AW    = 6
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [NODES-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [NODES-1:0] rd_data
);
    logic [NODES-1:0] mem [NODES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/digraph_cycle_detector_top.sv =====
// Directed graph cycle detector: edge loader, search sequencer and result register.
//
// Usage:
// - Write node_count through cfg_valid/cfg_ready/cfg_data while the block is idle.
//   MAX_NODES may be 1 to 64; the node fields are 6 bits wide.
// - Send edges on s_*. A stored edge takes a read-modify-write of one matrix row, so
//   s_ready stays low from its accept until the row is written back; a word that
//   stores nothing and is not the last leaves s_ready high for the next word.
// - A word with s_last_edge high starts a depth-first search: each candidate
//   (node, target) pair takes an issue step and a use step, each root likewise,
//   and a pop reloads the parent from the stack when one remains.
// - The result is one word on m_acyclic; it stays in its output register until
//   m_ready takes it. A stall there holds the block before the clearing sweep.
// - After each answer the matrix and the visit marks are swept, one entry a cycle;
//   s_ready is low meanwhile.
// - Reset clears node_count and the control state, then runs the same sweep
//   before the first edge is accepted.
`default_nettype none
module digraph_cycle_detector_top
    import dcd_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [6:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_edge_present,
    input  wire logic [5:0] s_edge_source,
    input  wire logic [5:0] s_edge_target,
    input  wire logic       s_last_edge,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_acyclic
);
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    dcd_state_t state_reg, state_next;

    logic [6:0]    node_count_reg;
    logic [CW-1:0] n_lim;
    logic [1:0]    mark_mem [MAX_NODES];
    logic [1:0]    mark_rd;
    logic          mark_we;
    logic [AW-1:0] mark_wa, mark_ra;
    logic [1:0]    mark_wd;
    logic [AW-1:0] stk_node_mem [MAX_NODES];
    logic [CW-1:0] stk_next_mem [MAX_NODES];
    logic [AW-1:0] stk_node_rd;
    logic [CW-1:0] stk_next_rd;
    logic          stk_we;
    logic [AW-1:0] stk_wa, stk_ra;
    logic [AW-1:0] top_v_reg;
    logic [CW-1:0] top_j_reg;
    logic [CW-1:0] depth_reg;
    logic [CW-1:0] root_reg;
    logic [1:0]    phase_reg;
    logic [AW-1:0] clr_reg;
    logic          res_valid_reg, res_acyc_reg;
    logic          cyc_reg;
    logic          have_edge_reg, last_reg;
    logic [AW-1:0] e_src_reg, e_dst_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_wa, mem_ra;
    logic [MAX_NODES-1:0] mem_wd, mem_rd;

    logic root_done, root_take;
    logic step_pop, step_cycle, step_push;

    // Saturate node count to MAX_NODES.
    always_comb begin
        if ({25'd0, node_count_reg} > MAX_NODES) begin
            n_lim = CW'(MAX_NODES);
        end else begin
            n_lim = CW'(node_count_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = res_valid_reg;
    assign m_acyclic = res_acyc_reg;

    dcd_adj_mem #(.NODES(MAX_NODES), .AW(AW)) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    // Read address: edge source while loading, top node while searching.
    always_comb begin
        mem_ra = (state_reg == ST_LOAD) ? e_src_reg : top_v_reg;
        mem_we = 1'b0;
        mem_wa = e_src_reg;
        mem_wd = mem_rd | (MAX_NODES'(1) << e_dst_reg);
        if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = clr_reg;
            mem_wd = '0;
        end else if (state_reg == ST_LOAD && have_edge_reg && phase_reg == 2'd2) begin
            mem_we = 1'b1;
        end
    end

    // Search decisions; mark and row reads issued in PH_ISSUE are registered and used in PH_USE.
    assign root_done  = cyc_reg || (root_reg >= n_lim);
    assign root_take  = (state_reg == ST_ROOT) && !root_done && (phase_reg == PH_USE)
                        && (mark_rd == MARK_FREE);
    assign step_pop   = (state_reg == ST_STEP) && (depth_reg != '0)
                        && (phase_reg == PH_ISSUE) && (top_j_reg >= n_lim);
    assign step_cycle = (state_reg == ST_STEP) && (depth_reg != '0)
                        && (phase_reg == PH_USE) && mem_rd[top_j_reg[AW-1:0]]
                        && (mark_rd == MARK_PATH);
    assign step_push  = (state_reg == ST_STEP) && (depth_reg != '0)
                        && (phase_reg == PH_USE) && mem_rd[top_j_reg[AW-1:0]]
                        && (mark_rd == MARK_FREE) && (depth_reg < CW'(MAX_NODES));

    always_comb begin
        mark_ra = (state_reg == ST_ROOT) ? root_reg[AW-1:0] : top_j_reg[AW-1:0];
        mark_we = 1'b0;
        mark_wa = top_v_reg;
        mark_wd = MARK_DONE;
        if (state_reg == ST_CLEAR) begin
            mark_we = 1'b1;
            mark_wa = clr_reg;
            mark_wd = MARK_FREE;
        end else if (root_take) begin
            mark_we = 1'b1;
            mark_wa = root_reg[AW-1:0];
            mark_wd = MARK_PATH;
        end else if (step_pop) begin
            mark_we = 1'b1;
        end else if (step_push) begin
            mark_we = 1'b1;
            mark_wa = top_j_reg[AW-1:0];
            mark_wd = MARK_PATH;
        end
    end

    // Stack below the top entry: save the parent on push, read it back on pop.
    assign stk_we = step_push;
    assign stk_wa = AW'(depth_reg - 1'b1);
    assign stk_ra = AW'(depth_reg - 2'd2);

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_wa] <= mark_wd;
        end
        mark_rd <= mark_mem[mark_ra];
        if (stk_we) begin
            stk_node_mem[stk_wa] <= top_v_reg;
            stk_next_mem[stk_wa] <= top_j_reg + 1'b1;
        end
        stk_node_rd <= stk_node_mem[stk_ra];
        stk_next_rd <= stk_next_mem[stk_ra];
    end

    assign s_ready = (state_reg == ST_LOAD) && !have_edge_reg && !last_reg;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (last_reg && !have_edge_reg) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_ANSWER;
                end else if (root_take) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (depth_reg == '0) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ANSWER: begin
                if (!res_valid_reg) begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (clr_reg == AW'(MAX_NODES - 1)) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            node_count_reg <= '0;
            depth_reg      <= '0;
            root_reg       <= '0;
            phase_reg      <= '0;
            clr_reg        <= '0;
            res_valid_reg  <= 1'b0;
            res_acyc_reg   <= 1'b0;
            cyc_reg        <= 1'b0;
            have_edge_reg  <= 1'b0;
            last_reg       <= 1'b0;
            top_v_reg      <= '0;
            top_j_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end
            if (m_valid && m_ready) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (s_valid && s_ready) begin
                        have_edge_reg <= s_edge_present
                            && ({1'b0, s_edge_source} < 7'(n_lim))
                            && ({1'b0, s_edge_target} < 7'(n_lim));
                        e_src_reg     <= AW'(s_edge_source);
                        e_dst_reg     <= AW'(s_edge_target);
                        last_reg      <= s_last_edge;
                        phase_reg     <= 2'd0;
                    end else if (have_edge_reg) begin
                        // read, wait for row, write back
                        if (phase_reg == 2'd2) begin
                            have_edge_reg <= 1'b0;
                        end
                        phase_reg <= phase_reg + 2'd1;
                    end else if (last_reg) begin
                        last_reg  <= 1'b0;
                        root_reg  <= '0;
                        cyc_reg   <= 1'b0;
                        depth_reg <= '0;
                        phase_reg <= PH_ISSUE;
                    end
                end
                ST_ROOT: begin
                    if (!root_done) begin
                        if (phase_reg == PH_ISSUE) begin
                            phase_reg <= PH_USE;
                        end else begin
                            phase_reg <= PH_ISSUE;
                            root_reg  <= root_reg + 1'b1;
                            if (root_take) begin
                                top_v_reg <= root_reg[AW-1:0];
                                top_j_reg <= '0;
                                depth_reg <= CW'(1);
                            end
                        end
                    end
                end
                ST_STEP: begin
                    if (depth_reg != '0) begin
                        case (phase_reg)
                            PH_ISSUE: begin
                                if (step_pop) begin
                                    depth_reg <= depth_reg - 1'b1;
                                    phase_reg <= (depth_reg > CW'(1)) ? PH_RELOAD : PH_ISSUE;
                                end else begin
                                    phase_reg <= PH_USE;
                                end
                            end
                            PH_USE: begin
                                phase_reg <= PH_ISSUE;
                                top_j_reg <= top_j_reg + 1'b1;
                                if (step_cycle) begin
                                    cyc_reg   <= 1'b1;
                                    depth_reg <= '0;
                                end else if (step_push) begin
                                    top_v_reg <= top_j_reg[AW-1:0];
                                    top_j_reg <= '0;
                                    depth_reg <= depth_reg + 1'b1;
                                end
                            end
                            PH_RELOAD: begin
                                top_v_reg <= stk_node_rd;
                                top_j_reg <= stk_next_rd;
                                phase_reg <= PH_ISSUE;
                            end
                            default: phase_reg <= PH_ISSUE;
                        endcase
                    end
                end
                ST_ANSWER: begin
                    if (!res_valid_reg && state_next == ST_ANSWER) begin
                        res_valid_reg <= 1'b0;
                    end
                end
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (state_next == ST_LOAD) begin
                        clr_reg <= '0;
                    end
                end
                default: ;
            endcase
            // Raise the result on the way out of the search.
            if (state_reg == ST_ROOT && state_next == ST_ANSWER) begin
                res_valid_reg <= 1'b1;
                res_acyc_reg  <= !cyc_reg;
            end
        end
    end

`ifndef SYNTHESIS
    a_ready_only_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_LOAD)) else $error("ready outside load");
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_acyclic)))
        else $error("result dropped");
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= CW'(MAX_NODES)) else $error("stack overflow");
`endif
endmodule
`default_nettype wire
